// ===== src/chunked_bitmap_page_allocator_defines.svh =====
// Assertion helpers for the page allocator.
`ifndef CHUNKED_BITMAP_PAGE_ALLOCATOR_DEFINES_SVH
`define CHUNKED_BITMAP_PAGE_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, off while in reset.
`define CBPA_ASSERT_IMP(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("cbpa: implication check failed");

// Next-cycle implication, off while in reset.
`define CBPA_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("cbpa: next-cycle check failed");

`endif

// ===== src/cbpa_pkg.sv =====
package cbpa_pkg;

	localparam int PAGES_PER_CHUNK = 256;
	localparam int WORD_BITS       = 64;
	localparam int WORDS_PER_CHUNK = PAGES_PER_CHUNK / WORD_BITS;
	localparam int WORD_IDX_W      = 6;
	localparam int LWORD_W         = 2;
	localparam int LPAGE_W         = 8;
	localparam int CNT_W           = 9;
	localparam int PID_W           = 12;
	localparam int RSV_W           = 8;
	localparam int FREED_W         = 32;
	localparam int OUT_DATA_W      = 48;
	localparam int IN_DATA_W       = 16;

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	typedef enum logic [1:0] {
		STAT_OK       = 2'd0,
		STAT_NOFREE   = 2'd1,
		STAT_NOTALLOC = 2'd2,
		STAT_RSVD     = 2'd3
	} alloc_status_t;

	typedef enum logic [3:0] {
		CMD_NOP,
		CMD_CLEAR,
		CMD_LOAD,
		CMD_CHK_CNT,
		CMD_STEP,
		CMD_OPEN,
		CMD_SCAN_INIT,
		CMD_SCAN_CHK,
		CMD_FAIL,
		CMD_F_RD,
		CMD_F_CHK,
		CMD_PUSH
	} dp_cmd_t;

	typedef struct packed {
		logic clr_last;
		logic cnt_full;
		logic cnt_zero;
		logic srch_last;
		logic open_more;
		logic scan_hit;
		logic scan_last;
		logic out_free;
	} dp_stat_t;

endpackage

// ===== src/cbpa_ctrl.sv =====
module cbpa_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_op,
	output logic               in_ready,
	input  cbpa_pkg::dp_stat_t stat,
	output cbpa_pkg::dp_cmd_t  cmd
);
	import cbpa_pkg::*;

	typedef enum logic [3:0] {
		ST_CLR, ST_IDLE, ST_RD, ST_CHK, ST_STEP, ST_OPEN, ST_SCI, ST_SCRD,
		ST_SCCHK, ST_FAIL, ST_FRD, ST_FCHK, ST_DONE
	} state_t;

	state_t state_q, state_nxt;

	always_comb begin
		state_nxt = state_q;
		cmd       = CMD_NOP;
		unique case (state_q)
			ST_CLR: begin
				cmd = CMD_CLEAR;
				if (stat.clr_last) state_nxt = ST_IDLE;
			end
			ST_IDLE: begin
				if (in_valid) begin
					cmd       = CMD_LOAD;
					state_nxt = (in_op == OP_FREE) ? ST_FRD : ST_RD;
				end
			end
			ST_RD: state_nxt = ST_CHK;
			ST_CHK: begin
				cmd = CMD_CHK_CNT;
				priority if (stat.cnt_full) state_nxt = stat.srch_last ? ST_FAIL : ST_STEP;
				else if (stat.cnt_zero) state_nxt = ST_OPEN;
				else state_nxt = ST_SCI;
			end
			ST_STEP: begin
				cmd       = CMD_STEP;
				state_nxt = ST_CHK;
			end
			ST_OPEN: begin
				if (stat.open_more) cmd = CMD_OPEN;
				else state_nxt = ST_SCI;
			end
			ST_SCI: begin
				cmd       = CMD_SCAN_INIT;
				state_nxt = ST_SCRD;
			end
			ST_SCRD: state_nxt = ST_SCCHK;
			ST_SCCHK: begin
				cmd = CMD_SCAN_CHK;
				priority if (stat.scan_hit) state_nxt = ST_DONE;
				else if (stat.scan_last) state_nxt = ST_FAIL;
				else state_nxt = ST_SCRD;
			end
			ST_FAIL: begin
				cmd       = CMD_FAIL;
				state_nxt = ST_DONE;
			end
			ST_FRD: begin
				cmd       = CMD_F_RD;
				state_nxt = ST_FCHK;
			end
			ST_FCHK: begin
				cmd       = CMD_F_CHK;
				state_nxt = ST_DONE;
			end
			ST_DONE: begin
				if (stat.out_free) begin
					cmd       = CMD_PUSH;
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	assign in_ready = (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

// ===== src/cbpa_dp.sv =====
module cbpa_dp #(
	parameter int NUM_CHUNKS = 16,
	parameter int CW         = 4,
	parameter int AW         = 6
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  cbpa_pkg::dp_cmd_t                    cmd,
	output cbpa_pkg::dp_stat_t                   stat,
	input  logic                                 cfg_we,
	input  logic [cbpa_pkg::RSV_W-1:0]           cfg_wdata,
	input  logic [cbpa_pkg::PID_W-1:0]           in_page_id,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [cbpa_pkg::OUT_DATA_W-1:0]      out_data
);
	import cbpa_pkg::*;

	localparam int WORDS = NUM_CHUNKS * WORDS_PER_CHUNK;

	logic [WORD_BITS-1:0] bm_mem [WORDS];
	logic [CNT_W-1:0]     cnt_mem [NUM_CHUNKS];

	logic [RSV_W-1:0]     rsv_q;
	logic [PID_W-1:0]     pid_q;
	logic [CW-1:0]        ck_q, cur_q, n_q;
	logic [LWORD_W:0]     wi_q;
	logic [CNT_W-1:0]     cnt_q, cnt_rd_q;
	logic [AW-1:0]        clr_q;
	logic [WORD_BITS-1:0] bm_rd_q;
	logic [FREED_W-1:0]   freed_q;
	logic [PID_W-1:0]     res_pid_q;
	alloc_status_t        res_st_q;
	logic                 out_valid_q;
	logic [OUT_DATA_W-1:0] out_data_q;

	logic [CW-1:0]          ck_nxt, pid_ck_a, cnt_raddr, cnt_waddr;
	logic [AW-1:0]          pid_word, cur_word, bm_raddr, bm_waddr;
	logic [LPAGE_W-PID_W+PID_W-LPAGE_W+3:0] pid_ck;
	logic                   pid_ck_ok, free_bit, free_rsv;
	logic [LWORD_W-1:0]     rsv_word;
	logic [WORD_IDX_W-1:0]  rsv_bit, hit_idx;
	logic [WORD_BITS-1:0]   scan_mask, scan_free, open_data, bm_wdata;
	logic [LWORD_W:0]       open_words;
	logic                   scan_hit, bm_we, cnt_we;
	logic [CNT_W-1:0]       cnt_wdata;
	alloc_status_t          f_status;

	assign ck_nxt    = (ck_q == CW'(NUM_CHUNKS - 1)) ? '0 : ck_q + 1'b1;
	assign pid_ck    = pid_q[PID_W-1:LPAGE_W];
	assign pid_ck_ok = (int'(pid_ck) < NUM_CHUNKS);
	assign pid_ck_a  = CW'(pid_ck);
	assign pid_word  = AW'(pid_q[PID_W-1:WORD_IDX_W]);
	assign cur_word  = {ck_q, wi_q[LWORD_W-1:0]};
	assign rsv_word  = rsv_q[RSV_W-1:WORD_IDX_W];
	assign rsv_bit   = rsv_q[WORD_IDX_W-1:0];

	assign cnt_raddr = (cmd == CMD_STEP) ? ck_nxt : (cmd == CMD_F_RD) ? pid_ck_a : ck_q;
	assign bm_raddr  = (cmd == CMD_F_RD) ? pid_word : cur_word;

	// Pages below the reserved count never take part in the scan.
	assign scan_mask  = (wi_q[LWORD_W-1:0] == rsv_word) ? ({WORD_BITS{1'b1}} << rsv_bit)
		: {WORD_BITS{1'b1}};
	assign scan_free  = ~bm_rd_q & scan_mask;
	assign scan_hit   = |scan_free;
	assign open_words = {1'b0, rsv_word} + {{LWORD_W{1'b0}}, |rsv_bit};
	assign open_data  = (wi_q < {1'b0, rsv_word}) ? {WORD_BITS{1'b1}}
		: (({{(WORD_BITS-1){1'b0}}, 1'b1} << rsv_bit) - 1'b1);

	always_comb begin
		hit_idx = '0;
		for (int i = WORD_BITS - 1; i >= 0; i--) begin
			if (scan_free[i]) hit_idx = WORD_IDX_W'(i);
		end
	end

	assign free_bit = bm_rd_q[pid_q[WORD_IDX_W-1:0]];
	assign free_rsv = (pid_q[LPAGE_W-1:0] < rsv_q);

	always_comb begin
		priority if (!pid_ck_ok) f_status = STAT_NOTALLOC;
		else if (free_rsv) f_status = STAT_RSVD;
		else if (!free_bit) f_status = STAT_NOTALLOC;
		else f_status = STAT_OK;
	end

	always_comb begin
		bm_we     = 1'b0;
		bm_waddr  = cur_word;
		bm_wdata  = '0;
		cnt_we    = 1'b0;
		cnt_waddr = ck_q;
		cnt_wdata = '0;
		unique case (cmd)
			CMD_CLEAR: begin
				bm_we     = 1'b1;
				bm_waddr  = clr_q;
				cnt_we    = 1'b1;
				cnt_waddr = clr_q[AW-1:LWORD_W];
			end
			CMD_CHK_CNT: begin
				// opening a fresh chunk: its count becomes the reserved number
				cnt_we    = ~cnt_rd_q[CNT_W-1] & (cnt_rd_q == '0);
				cnt_wdata = CNT_W'(rsv_q);
			end
			CMD_OPEN: begin
				bm_we    = 1'b1;
				bm_wdata = open_data;
			end
			CMD_SCAN_CHK: begin
				bm_we     = scan_hit;
				bm_wdata  = bm_rd_q | ({{(WORD_BITS-1){1'b0}}, 1'b1} << hit_idx);
				cnt_we    = scan_hit;
				cnt_wdata = cnt_q + 1'b1;
			end
			CMD_F_CHK: begin
				bm_we     = (f_status == STAT_OK);
				bm_waddr  = pid_word;
				bm_wdata  = bm_rd_q & ~({{(WORD_BITS-1){1'b0}}, 1'b1} << pid_q[WORD_IDX_W-1:0]);
				cnt_we    = (f_status == STAT_OK);
				cnt_waddr = pid_ck_a;
				cnt_wdata = (cnt_rd_q == '0) ? '0 : cnt_rd_q - 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (bm_we) bm_mem[bm_waddr] <= bm_wdata;
		bm_rd_q <= bm_mem[bm_raddr];
	end

	always_ff @(posedge clk) begin
		if (cnt_we) cnt_mem[cnt_waddr] <= cnt_wdata;
		cnt_rd_q <= cnt_mem[cnt_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsv_q       <= RSV_W'(1);
			ck_q        <= '0;
			cur_q       <= '0;
			n_q         <= '0;
			wi_q        <= '0;
			clr_q       <= '0;
			freed_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) rsv_q <= cfg_wdata;
			if (cmd == CMD_PUSH) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
			unique case (cmd)
				CMD_CLEAR: clr_q <= clr_q + 1'b1;
				CMD_LOAD: begin
					ck_q <= cur_q;
					n_q  <= '0;
				end
				CMD_CHK_CNT: begin
					wi_q <= '0;
					if (!cnt_rd_q[CNT_W-1]) cur_q <= ck_q;
				end
				CMD_STEP: begin
					ck_q <= ck_nxt;
					n_q  <= n_q + 1'b1;
				end
				CMD_OPEN: wi_q <= wi_q + 1'b1;
				CMD_SCAN_INIT: wi_q <= {1'b0, rsv_word};
				CMD_SCAN_CHK: if (!scan_hit) wi_q <= wi_q + 1'b1;
				CMD_F_CHK: if (f_status == STAT_OK) freed_q <= freed_q + 1'b1;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (cmd)
			CMD_LOAD: pid_q <= in_page_id;
			CMD_CHK_CNT: cnt_q <= (cnt_rd_q == '0) ? CNT_W'(rsv_q) : cnt_rd_q;
			CMD_SCAN_CHK: begin
				res_pid_q <= PID_W'({ck_q, wi_q[LWORD_W-1:0], hit_idx});
				res_st_q  <= STAT_OK;
			end
			CMD_FAIL: begin
				res_pid_q <= '0;
				res_st_q  <= STAT_NOFREE;
			end
			CMD_F_CHK: begin
				res_pid_q <= pid_q;
				res_st_q  <= f_status;
			end
			CMD_PUSH: out_data_q <= {2'b00, freed_q, res_st_q, res_pid_q};
			default: begin
			end
		endcase
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	assign stat.clr_last  = (clr_q == AW'(WORDS - 1));
	assign stat.cnt_full  = cnt_rd_q[CNT_W-1];
	assign stat.cnt_zero  = (cnt_rd_q == '0);
	assign stat.srch_last = (n_q == CW'(NUM_CHUNKS - 1));
	assign stat.open_more = (wi_q < open_words);
	assign stat.scan_hit  = scan_hit;
	assign stat.scan_last = (wi_q[LWORD_W-1:0] == LWORD_W'(WORDS_PER_CHUNK - 1));
	assign stat.out_free  = ~out_valid_q | out_ready;

endmodule

// ===== src/chunked_bitmap_page_allocator.sv =====
// Page allocator over NUM_CHUNKS chunks of 256 pages. An item on s_* either allocates the
// lowest free non-reserved page (searching onward from the current chunk, with wrap, when
// it is full) or frees a page; each item gives one result on m_*. After reset the block
// sweeps its bitmap and count memories with s_tready low; cfg writes are taken during
// that time. One item at a time: a free reads the page's bitmap word and chunk count and
// writes both back if the free is valid; an allocate reads the current chunk's count,
// steps to the next chunk while it is full, marks the reserved pages of a chunk opened
// for the first time word by word, then scans its 64-page words upward from the reserved
// one and marks the first free page. Both memories have a registered read port.
`include "chunked_bitmap_page_allocator_defines.svh"

module chunked_bitmap_page_allocator #(
	parameter int NUM_CHUNKS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [7:0]  cfg_wdata,   // reserved_pages
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,     // [11:0] page_id, zero fill above
	input  logic [0:0]  s_tuser,     // [0] op
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata      // [11:0] page_id_res, [13:12] status, [45:14] freed_total
);
	import cbpa_pkg::*;

	localparam int CW = (NUM_CHUNKS > 1) ? $clog2(NUM_CHUNKS) : 1;
	localparam int AW = CW + LWORD_W;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	cbpa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_op    (s_tuser[0]),
		.in_ready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	cbpa_dp #(
		.NUM_CHUNKS (NUM_CHUNKS),
		.CW         (CW),
		.AW         (AW)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.in_page_id (s_tdata[PID_W-1:0]),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_data   (m_tdata)
	);

	// one item in flight: no second accept right after the first
	`CBPA_ASSERT_NEXT(a_one_in_flight, clk, arst_n, s_tvalid && s_tready, !s_tready)
	// a failed allocate reports page zero
	`CBPA_ASSERT_IMP(a_nofree_zero, clk, arst_n, m_tvalid && (m_tdata[13:12] == STAT_NOFREE), m_tdata[11:0] == '0)

endmodule

// ===== tb/chunked_bitmap_page_allocator_tb.sv =====
`timescale 1ns / 100ps

module chunked_bitmap_page_allocator_tb;
	import cbpa_pkg::*;

	localparam int N_CHUNKS    = 16;
	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_WAIT  = 60;

	typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

	typedef struct {
		row_kind_t     kind;
		logic          op;
		logic [11:0]   pid;
		logic          typed;
		logic [11:0]   exp_pid;
		alloc_status_t exp_stat;
		logic [31:0]   exp_freed;
	} stim_row_t;

	typedef struct {
		logic [11:0]   pid;
		alloc_status_t stat;
		logic [31:0]   freed;
	} alloc_result_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [7:0]  cfg_wdata;
	logic        s_tvalid;
	logic        s_tready;
	logic [15:0] s_tdata;
	logic [0:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [47:0] m_tdata;

	// allocator shadow state
	logic [255:0] shadow_bitmap [N_CHUNKS];
	logic [8:0]   shadow_count [N_CHUNKS];
	logic [3:0]   shadow_cur;
	logic [31:0]  shadow_freed;
	logic [7:0]   shadow_rsv;

	alloc_result_t pending_results [$];
	logic [11:0]   held_pages [$];
	stim_row_t     stim_rows [$];
	int            errors;
	int            stall_pct;
	int            cycle_count;

	chunked_bitmap_page_allocator u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic void open_chunk(input int ck);
		if (shadow_count[ck] == 0) begin
			for (int i = 0; i < shadow_rsv; i++)
				shadow_bitmap[ck][i] = 1'b1;
			shadow_count[ck] = 9'(shadow_rsv);
		end
	endfunction

	function automatic alloc_result_t apply_request(input logic op, input logic [11:0] pid);
		alloc_result_t res;
		int ck;
		int c;
		logic found;
		logic [3:0] fck;
		logic [7:0] lp;
		res.pid   = '0;
		res.stat  = STAT_NOFREE;
		if (op == OP_ALLOC) begin
			ck = shadow_cur;
			found = 1'b1;
			open_chunk(ck);
			if (shadow_count[ck] >= 256) begin
				found = 1'b0;
				for (int i = 0; i < N_CHUNKS; i++) begin
					c = (ck + i) % N_CHUNKS;
					if (!found && shadow_count[c] < 256) begin
						found = 1'b1;
						fck = 4'(c);
					end
				end
				if (found) begin
					ck = fck;
					shadow_cur = fck;
					open_chunk(ck);
				end
			end
			if (found) begin
				for (int p = shadow_rsv; p < 256; p++) begin
					if (res.stat == STAT_NOFREE && !shadow_bitmap[ck][p]) begin
						shadow_bitmap[ck][p] = 1'b1;
						shadow_count[ck] = shadow_count[ck] + 1;
						res.pid  = {4'(ck), 8'(p)};
						res.stat = STAT_OK;
						held_pages.push_back(res.pid);
					end
				end
			end
		end else begin
			ck = pid[11:8];
			lp = pid[7:0];
			res.pid = pid;
			if (!shadow_bitmap[ck][lp])
				res.stat = (lp < shadow_rsv) ? STAT_RSVD : STAT_NOTALLOC;
			else if (lp < shadow_rsv)
				res.stat = STAT_RSVD;
			else begin
				shadow_bitmap[ck][lp] = 1'b0;
				if (shadow_count[ck] > 0)
					shadow_count[ck] = shadow_count[ck] - 1;
				shadow_freed = shadow_freed + 1;
				res.stat = STAT_OK;
				foreach (held_pages[i])
					if (held_pages[i] == pid) begin
						held_pages.delete(i);
						break;
					end
			end
		end
		res.freed = shadow_freed;
		return res;
	endfunction

	// Present one item and hold it until accepted; valid stays high on return.
	task automatic send_item(input logic op, input logic [11:0] pid, input logic typed,
			input alloc_result_t typed_res);
		alloc_result_t res;
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {4'b0, pid};
		do @(posedge clk); while (!s_tready);
		res = apply_request(op, pid);
		pending_results.push_back(typed ? typed_res : res);
	endtask

	task automatic drain_results();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reserved(input logic [7:0] value);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we    <= 1'b0;
		shadow_rsv = value;
	endtask

	task automatic add_row(input row_kind_t kind, input logic op, input logic [11:0] pid,
			input logic typed, input logic [11:0] epid, input alloc_status_t estat,
			input logic [31:0] efreed);
		stim_row_t row;
		row.kind      = kind;
		row.op        = op;
		row.pid       = pid;
		row.typed     = typed;
		row.exp_pid   = epid;
		row.exp_stat  = estat;
		row.exp_freed = efreed;
		stim_rows.push_back(row);
	endtask

	task automatic run_phase(input logic [7:0] rsv, input int idle_pct, input int stall,
			input int n_items);
		alloc_result_t none;
		logic op;
		logic [11:0] pid;
		none = '{pid: '0, stat: STAT_OK, freed: '0};
		drain_results();
		write_reserved(rsv);
		stall_pct = stall;
		for (int n = 0; n < n_items; n++) begin
			while ($urandom_range(0, 99) < idle_pct) begin
				s_tvalid <= 1'b0;
				@(posedge clk);
			end
			op = ($urandom_range(0, 99) < 55) ? OP_ALLOC : OP_FREE;
			if (op == OP_FREE && held_pages.size() != 0 && $urandom_range(0, 99) < 70)
				pid = held_pages[$urandom_range(0, held_pages.size() - 1)];
			else
				pid = 12'($urandom_range(0, 4095));
			send_item(op, pid, 1'b0, none);
		end
	endtask

	// compare each result with the oldest expectation
	always @(posedge clk) begin
		alloc_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				$error("result with no expectation: tdata=%h", m_tdata);
				errors++;
			end else begin
				want = pending_results.pop_front();
				if (m_tdata[11:0] !== want.pid) begin
					$error("page_id_res: expected %0d, got %0d", want.pid, m_tdata[11:0]);
					errors++;
				end
				if (m_tdata[13:12] !== want.stat) begin
					$error("status: expected %0d, got %0d", want.stat, m_tdata[13:12]);
					errors++;
				end
				if (m_tdata[45:14] !== want.freed) begin
					$error("freed_total: expected %0d, got %0d", want.freed, m_tdata[45:14]);
					errors++;
				end
			end
		end
		m_tready <= ($urandom_range(0, 99) >= stall_pct);
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		alloc_result_t typed_res;
		errors      = 0;
		stall_pct   = 0;
		cycle_count = 0;
		arst_n      = 1'b0;
		cfg_we      = 1'b0;
		cfg_wdata   = '0;
		s_tvalid    = 1'b0;
		s_tdata     = '0;
		s_tuser     = OP_ALLOC;
		foreach (shadow_bitmap[i]) begin
			shadow_bitmap[i] = '0;
			shadow_count[i]  = '0;
		end
		shadow_cur   = '0;
		shadow_freed = '0;
		shadow_rsv   = 8'd1;

		// one usable page per chunk, so the pool fills after 16 allocations
		add_row(ROW_CFG, OP_ALLOC, 12'd255, 1'b0, '0, STAT_OK, 0);
		for (int k = 0; k < N_CHUNKS; k++)
			add_row(ROW_ITEM, OP_ALLOC, 12'd0, 1'b1, 12'(k * 256 + 255), STAT_OK, 0);
		add_row(ROW_ITEM, OP_ALLOC, 12'd0,     1'b1, 12'd0,     STAT_NOFREE,   0);
		add_row(ROW_ITEM, OP_FREE,  12'd255,   1'b1, 12'd255,   STAT_OK,       1);
		add_row(ROW_ITEM, OP_FREE,  12'd0,     1'b1, 12'd0,     STAT_RSVD,     1);
		add_row(ROW_ITEM, OP_FREE,  12'd255,   1'b1, 12'd255,   STAT_NOTALLOC, 1);
		// search wraps from the last chunk back to chunk 0
		add_row(ROW_ITEM, OP_ALLOC, 12'd0,     1'b1, 12'd255,   STAT_OK,       1);
		add_row(ROW_ITEM, OP_ALLOC, 12'd4095,  1'b1, 12'd0,     STAT_NOFREE,   1);
		add_row(ROW_CFG,  OP_ALLOC, 12'd1,     1'b0, '0,        STAT_OK,       0);
		add_row(ROW_ITEM, OP_FREE,  12'h100,   1'b1, 12'h100,   STAT_RSVD,     1);
		add_row(ROW_CFG,  OP_ALLOC, 12'd0,     1'b0, '0,        STAT_OK,       0);
		add_row(ROW_ITEM, OP_FREE,  12'h100,   1'b1, 12'h100,   STAT_OK,       2);
		add_row(ROW_ITEM, OP_ALLOC, 12'd0,     1'b1, 12'h100,   STAT_OK,       2);
		add_row(ROW_ITEM, OP_FREE,  12'hfff,   1'b1, 12'hfff,   STAT_OK,       3);
		add_row(ROW_ITEM, OP_FREE,  12'hfff,   1'b1, 12'hfff,   STAT_NOTALLOC, 3);
		add_row(ROW_ITEM, OP_ALLOC, 12'd0,     1'b0, '0,        STAT_OK,       0);

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		foreach (stim_rows[i]) begin
			if (stim_rows[i].kind == ROW_CFG) begin
				drain_results();
				write_reserved(stim_rows[i].pid[7:0]);
			end else begin
				typed_res.pid   = stim_rows[i].exp_pid;
				typed_res.stat  = stim_rows[i].exp_stat;
				typed_res.freed = stim_rows[i].exp_freed;
				send_item(stim_rows[i].op, stim_rows[i].pid, stim_rows[i].typed, typed_res);
			end
		end

		run_phase(8'd0,   0,  0,  130);
		run_phase(8'd200, 75, 0,  130);
		run_phase(8'd1,   0,  75, 130);
		run_phase(8'd128, 10, 10, 130);
		run_phase(8'($urandom_range(0, 255)), 0, 0, 130);

		drain_results();
		stall_pct = 0;
		repeat (DRAIN_WAIT) @(posedge clk);
		if (errors == 0 && pending_results.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
